FILE: design/fmprf_pkg.sv
// ----------------------------------------------------------------------------
// First-match packet rule filter: shared package
// Rule and packet header types, protocol codes, opcodes and netmask helpers.
// ----------------------------------------------------------------------------
package fmprf_pkg;

  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned PFX_W     = 6;
  localparam int unsigned HIT_IDX_W = 6;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic {
    OP_APPEND   = 1'b0,
    OP_CLASSIFY = 1'b1
  } opcode_t;

  localparam logic [1:0] DIR_INBOUND  = 2'd1;
  localparam logic [1:0] DIR_OUTBOUND = 2'd2;

  localparam logic [1:0] CLASS_TCP = 2'd1;
  localparam logic [1:0] CLASS_UDP = 2'd2;

  typedef struct packed {
    logic [1:0]           dir;
    logic [ADDR_BITS-1:0] src_addr;
    logic [PFX_W-1:0]     src_prefix;
    logic [15:0]          sport;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [PFX_W-1:0]     dst_prefix;
    logic [15:0]          dport;
    logic [1:0]           proto_class;
    logic                 action;
  } rule_t;

  typedef struct packed {
    logic [1:0]           dir;
    logic [7:0]           proto;
    logic [ADDR_BITS-1:0] src_addr;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [15:0]          sport;
    logic [15:0]          dport;
  } pkt_t;

  // Each bit of the leading-ones mask is computed on its own: bits below the
  // position are forced high, so the AND tells whether that bit and all bits above it are set.
  function automatic logic [PFX_W-1:0] mask_to_prefix(input logic [ADDR_BITS-1:0] mask);
    logic [ADDR_BITS-1:0] ones;
    logic [ADDR_BITS-1:0] low_fill;
    for (int i = 0; i < ADDR_BITS; i++) begin
      low_fill = (ADDR_BITS'(1) << i) - ADDR_BITS'(1);
      ones[i]  = &(mask | low_fill);
    end
    if (mask == '0) begin
      return PFX_W'(ADDR_BITS);
    end
    return PFX_W'($countones(ones));
  endfunction

  function automatic logic addr_match(input logic [ADDR_BITS-1:0] pkt_addr,
                                      input logic [ADDR_BITS-1:0] rule_addr,
                                      input logic [PFX_W-1:0]     prefix);
    logic [PFX_W-1:0]     pfx;
    logic [PFX_W-1:0]     sh;
    logic [ADDR_BITS-1:0] m;
    pfx = (prefix > PFX_W'(ADDR_BITS)) ? PFX_W'(ADDR_BITS) : prefix;
    sh  = PFX_W'(ADDR_BITS) - pfx;
    m   = {ADDR_BITS{1'b1}} << sh;
    if (rule_addr == '0 || pfx == '0) begin
      return 1'b1;
    end
    return ((pkt_addr ^ rule_addr) & m) == '0;
  endfunction

endpackage

FILE: design/fmprf_cell.sv
// ----------------------------------------------------------------------------
// First-match packet rule filter: rule cell
// Holds one rule. Loads a new rule on append, or takes its neighbor's rule
// while the ring rotates during a scan.
// ----------------------------------------------------------------------------
module fmprf_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  logic             wr_en,
  input  fmprf_pkg::rule_t wr_rule,
  input  fmprf_pkg::rule_t nbr_rule,
  output fmprf_pkg::rule_t rule
);
  import fmprf_pkg::*;

  rule_t rule_r;
  rule_t rule_nxt;

  always_comb begin
    priority if (wr_en) begin
      rule_nxt = wr_rule;
    end else if (shift_en) begin
      rule_nxt = nbr_rule;
    end else begin
      rule_nxt = rule_r;
    end
  end

  always_ff @(posedge clk) begin
    rule_r <= rule_nxt;
  end

  assign rule = rule_r;

endmodule

FILE: design/fmprf_match.sv
// ----------------------------------------------------------------------------
// First-match packet rule filter: rule comparator
// Checks the packet header against the rule at the head of the ring.
// ----------------------------------------------------------------------------
module fmprf_match (
  input  fmprf_pkg::rule_t rule,
  input  fmprf_pkg::pkt_t  pkt,
  output logic             hit
);
  import fmprf_pkg::*;

  logic dir_ok;
  logic proto_ok;
  logic addr_ok;
  logic port_ok;

  always_comb begin
    // A packet that is neither inbound nor outbound never matches.
    dir_ok = (pkt.dir == DIR_INBOUND || pkt.dir == DIR_OUTBOUND) && (rule.dir == pkt.dir);
    unique case (rule.proto_class)
      CLASS_TCP: proto_ok = (pkt.proto == PROTO_TCP);
      CLASS_UDP: proto_ok = (pkt.proto == PROTO_UDP);
      default:   proto_ok = 1'b1;
    endcase
    addr_ok = addr_match(pkt.src_addr, rule.src_addr, rule.src_prefix) &&
              addr_match(pkt.dst_addr, rule.dst_addr, rule.dst_prefix);
    port_ok = (rule.sport == '0 || rule.sport == pkt.sport) &&
              (rule.dport == '0 || rule.dport == pkt.dport);
    hit = dir_ok && proto_ok && addr_ok && port_ok;
  end

endmodule

FILE: design/first_match_packet_rule_filter.sv
// ----------------------------------------------------------------------------
// First-match packet rule filter
// Ordered rule table held in a rotating ring of rule cells. An append writes
// the next free cell. A classify rotates the ring once through the comparator
// at its head and keeps the first matching rule.
// ----------------------------------------------------------------------------
// Append: result registered in the cycle after the transaction; a new one may start each cycle while busy is low.
// Classify: the result follows one full rotation of the rule ring past a single
//   comparator; busy is high meanwhile.
// Reset empties the rule table (count cleared); cells are not cleared.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
module first_match_packet_rule_filter #(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [1:0]  in_direction,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_src_address,
  input  logic [31:0] in_dst_address,
  input  logic [15:0] in_src_port_num,
  input  logic [15:0] in_dst_port_num,
  input  logic [31:0] in_src_mask,
  input  logic [31:0] in_dst_mask,
  input  logic [1:0]  in_rule_proto_class,
  input  logic        in_rule_verdict,
  output logic        out_valid,
  output logic        out_verdict,
  output logic        out_rule_hit,
  output logic [5:0]  out_hit_index,
  output logic        out_table_full
);
  import fmprf_pkg::*;

  localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_RULES - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             hit_act_r, hit_act_nxt;
  pkt_t             pkt_r, pkt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_verdict_r, out_verdict_nxt;
  logic             out_rule_hit_r, out_rule_hit_nxt;
  logic [5:0]       out_hit_index_r, out_hit_index_nxt;
  logic             out_table_full_r, out_table_full_nxt;

  logic             accept;
  logic             table_full;
  logic             shift_en;
  logic             wr_en_any;
  logic             head_hit;
  logic             in_range;
  logic [IDX_W+HIT_IDX_W-1:0] idx_ext;
  rule_t            wr_rule;
  rule_t            ring [MAX_RULES];

  assign accept     = start && (state_r == ST_IDLE);
  assign table_full = (count_r == CNT_W'(MAX_RULES));
  assign in_range   = (CNT_W'(step_r) < count_r);

  always_comb begin
    wr_rule.dir         = in_direction;
    wr_rule.src_addr    = in_src_address;
    wr_rule.src_prefix  = mask_to_prefix(in_src_mask);
    wr_rule.sport       = in_src_port_num;
    wr_rule.dst_addr    = in_dst_address;
    wr_rule.dst_prefix  = mask_to_prefix(in_dst_mask);
    wr_rule.dport       = in_dst_port_num;
    wr_rule.proto_class = in_rule_proto_class;
    wr_rule.action      = in_rule_verdict;
  end

  // Ports of protocols other than TCP and UDP count as zero.
  always_comb begin
    pkt_nxt.dir      = in_direction;
    pkt_nxt.proto    = in_ip_protocol;
    pkt_nxt.src_addr = in_src_address;
    pkt_nxt.dst_addr = in_dst_address;
    if (in_ip_protocol == PROTO_TCP || in_ip_protocol == PROTO_UDP) begin
      pkt_nxt.sport = in_src_port_num;
      pkt_nxt.dport = in_dst_port_num;
    end else begin
      pkt_nxt.sport = '0;
      pkt_nxt.dport = '0;
    end
  end

  // Cell i takes the rule of cell i+1, so cell 0 shows rule k at step k and
  // a full rotation brings the ring back to its home position.
  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    fmprf_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .wr_en    (wr_en_any && (count_r[IDX_W-1:0] == IDX_W'(i))),
      .wr_rule  (wr_rule),
      .nbr_rule (ring[(i + 1) % MAX_RULES]),
      .rule     (ring[i])
    );
  end

  fmprf_match u_match (
    .rule (ring[0]),
    .pkt  (pkt_r),
    .hit  (head_hit)
  );

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    step_nxt           = step_r;
    hit_nxt            = hit_r;
    hit_idx_nxt        = hit_idx_r;
    hit_act_nxt        = hit_act_r;
    out_valid_nxt      = 1'b0;
    out_verdict_nxt    = out_verdict_r;
    out_rule_hit_nxt   = out_rule_hit_r;
    out_hit_index_nxt  = out_hit_index_r;
    out_table_full_nxt = out_table_full_r;
    shift_en           = 1'b0;
    wr_en_any          = 1'b0;
    idx_ext            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_APPEND) begin
            out_valid_nxt      = 1'b1;
            out_verdict_nxt    = 1'b0;
            out_rule_hit_nxt   = 1'b0;
            out_hit_index_nxt  = '0;
            out_table_full_nxt = table_full;
            if (!table_full) begin
              wr_en_any = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            state_nxt = ST_SCAN;
            step_nxt  = '0;
            hit_nxt   = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        shift_en = 1'b1;
        step_nxt = step_r + IDX_W'(1);
        if (!hit_r && in_range && head_hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = step_r;
          hit_act_nxt = ring[0].action;
        end
        if (step_r == LAST_STEP) begin
          state_nxt          = ST_IDLE;
          out_valid_nxt      = 1'b1;
          idx_ext            = {{HIT_IDX_W{1'b0}}, hit_idx_nxt};
          out_verdict_nxt    = hit_nxt ? hit_act_nxt : 1'b1;
          out_rule_hit_nxt   = hit_nxt;
          out_hit_index_nxt  = hit_nxt ? idx_ext[HIT_IDX_W-1:0] : '0;
          out_table_full_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r           <= step_nxt;
    hit_r            <= hit_nxt;
    hit_idx_r        <= hit_idx_nxt;
    hit_act_r        <= hit_act_nxt;
    out_verdict_r    <= out_verdict_nxt;
    out_rule_hit_r   <= out_rule_hit_nxt;
    out_hit_index_r  <= out_hit_index_nxt;
    out_table_full_r <= out_table_full_nxt;
    if (accept && in_opcode == OP_CLASSIFY) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_rule_hit   = out_rule_hit_r;
  assign out_hit_index  = out_hit_index_r;
  assign out_table_full = out_table_full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RULES))
    else $error("rule count exceeds table size");

  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_CLASSIFY) |=> busy && !out_valid)
    else $error("classify transaction did not start a scan");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && step_r == LAST_STEP) |=> out_valid && !busy)
    else $error("scan end did not produce a result");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (!out_rule_hit && !out_verdict))
    else $error("refused append carries classify fields");

endmodule

FILE: verif/fmprf_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match packet rule filter: result checker
// Watches the command and result ports, keeps its own copy of the rule table,
// works out the verdict of every accepted transaction and compares it with
// the strobed result in order.
// ----------------------------------------------------------------------------
module fmprf_verdict_checker #(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_opcode,
  input  logic [1:0]  in_direction,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_src_address,
  input  logic [31:0] in_dst_address,
  input  logic [15:0] in_src_port_num,
  input  logic [15:0] in_dst_port_num,
  input  logic [31:0] in_src_mask,
  input  logic [31:0] in_dst_mask,
  input  logic [1:0]  in_rule_proto_class,
  input  logic        in_rule_verdict,
  input  logic        out_valid,
  input  logic        out_verdict,
  input  logic        out_rule_hit,
  input  logic [5:0]  out_hit_index,
  input  logic        out_table_full,
  output int unsigned error_count,
  output int unsigned pending,
  output int unsigned appends_stored,
  output int unsigned appends_refused,
  output int unsigned packets_seen,
  output int unsigned packets_hit
);
  import fmprf_pkg::*;

  // A packet that reaches the end of the table unmatched is let through.
  localparam logic PASS_ON_MISS = 1'b1;

  typedef struct packed {
    logic       verdict;
    logic       rule_hit;
    logic [5:0] hit_index;
    logic       table_full;
  } filter_result_t;

  filter_result_t expected_verdicts[$];
  rule_t          acl_rules[MAX_RULES];
  int unsigned    rule_total;

  function automatic logic [5:0] leading_ones(input logic [31:0] mask);
    int n;
    if (mask == '0) begin
      return 6'd32;
    end
    n = 0;
    while (n < 32 && mask[31 - n]) begin
      n++;
    end
    return 6'(n);
  endfunction

  function automatic logic prefix_hit(input logic [31:0] pkt_addr,
                                      input logic [31:0] rule_addr,
                                      input logic [5:0]  pfx);
    logic [31:0] sel;
    if (rule_addr == '0 || pfx == '0) begin
      return 1'b1;
    end
    sel = ~32'h0 << (32 - int'(pfx));
    return ((pkt_addr ^ rule_addr) & sel) == '0;
  endfunction

  // Appends update the local table; classifies scan it in insertion order.
  function automatic filter_result_t predict_verdict(input opcode_t     op,
                                                     input logic [1:0]  dir,
                                                     input logic [7:0]  proto,
                                                     input logic [31:0] saddr,
                                                     input logic [31:0] daddr,
                                                     input logic [15:0] sport,
                                                     input logic [15:0] dport,
                                                     input logic [31:0] smask,
                                                     input logic [31:0] dmask,
                                                     input logic [1:0]  pclass,
                                                     input logic        act);
    filter_result_t res;
    rule_t          r;
    logic [15:0]    sp;
    logic [15:0]    dp;
    res = '0;
    if (op == OP_APPEND) begin
      if (rule_total >= MAX_RULES) begin
        res.table_full = 1'b1;
        appends_refused++;
      end else begin
        r.dir         = dir;
        r.src_addr    = saddr;
        r.src_prefix  = leading_ones(smask);
        r.sport       = sport;
        r.dst_addr    = daddr;
        r.dst_prefix  = leading_ones(dmask);
        r.dport       = dport;
        r.proto_class = pclass;
        r.action      = act;
        acl_rules[rule_total] = r;
        rule_total++;
        appends_stored++;
      end
      return res;
    end
    packets_seen++;
    sp = sport;
    dp = dport;
    // Ports only mean something for TCP and UDP.
    if (proto != PROTO_TCP && proto != PROTO_UDP) begin
      sp = '0;
      dp = '0;
    end
    res.verdict = PASS_ON_MISS;
    if (dir != DIR_INBOUND && dir != DIR_OUTBOUND) begin
      return res;
    end
    for (int i = 0; i < rule_total; i++) begin
      r = acl_rules[i];
      if (r.dir != dir) continue;
      if (r.proto_class == CLASS_TCP && proto != PROTO_TCP) continue;
      if (r.proto_class == CLASS_UDP && proto != PROTO_UDP) continue;
      if (!prefix_hit(saddr, r.src_addr, r.src_prefix)) continue;
      if (!prefix_hit(daddr, r.dst_addr, r.dst_prefix)) continue;
      if (r.sport != '0 && r.sport != sp) continue;
      if (r.dport != '0 && r.dport != dp) continue;
      res.verdict   = r.action;
      res.rule_hit  = 1'b1;
      res.hit_index = 6'(i);
      packets_hit++;
      break;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    filter_result_t want;
    if (!rst_n) begin
      expected_verdicts.delete();
      rule_total      = 0;
      error_count     = 0;
      pending         = 0;
      appends_stored  = 0;
      appends_refused = 0;
      packets_seen    = 0;
      packets_hit     = 0;
    end else begin
      // The result of an earlier transaction is retired before a new one is
      // taken in on the same edge.
      if (out_valid === 1'b1) begin
        if (expected_verdicts.size() == 0) begin
          error_count++;
          $display("%0t: result strobed with nothing outstanding, expected none, %s",
                   $time, "got");
          $display("  %0b/%0b/%0d/%0b",
                   out_verdict, out_rule_hit, out_hit_index, out_table_full);
        end else begin
          want = expected_verdicts.pop_front();
          check_field("verdict", 32'(want.verdict), 32'(out_verdict));
          check_field("rule_hit", 32'(want.rule_hit), 32'(out_rule_hit));
          check_field("hit_index", 32'(want.hit_index), 32'(out_hit_index));
          check_field("table_full", 32'(want.table_full), 32'(out_table_full));
        end
      end else if (out_valid !== 1'b0) begin
        check_field("out_valid", 32'(1'b0), 32'(out_valid));
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_verdicts.push_back(predict_verdict(opcode_t'(in_opcode), in_direction,
            in_ip_protocol, in_src_address, in_dst_address, in_src_port_num,
            in_dst_port_num, in_src_mask, in_dst_mask, in_rule_proto_class,
            in_rule_verdict));
      end
      pending = expected_verdicts.size();
    end
  end

endmodule

FILE: verif/tb_first_match_packet_rule_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match packet rule filter: testbench top
// Drives rule appends and packet classifications, first a directed set and
// then random traffic built around the stored rules, under several idle
// patterns. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_first_match_packet_rule_filter;
  import fmprf_pkg::*;

  localparam int unsigned MAX_RULES    = 64;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_TXNS  = 1932;
  localparam int unsigned APPEND_PCT   = 7;
  localparam int unsigned DERIVED_PCT  = 60;
  localparam int unsigned DRAIN_CYCLES = MAX_RULES + 8;
  localparam int unsigned TIMEOUT_NS   = 20_000_000;

  localparam logic [1:0] DIR_NONE   = 2'd0;
  localparam logic [1:0] DIR_RSVD   = 2'd3;
  localparam logic [1:0] CLASS_ANY  = 2'd0;
  localparam logic [1:0] CLASS_RSVD = 2'd3;
  localparam logic       VERDICT_DROP   = 1'b0;
  localparam logic       VERDICT_ACCEPT = 1'b1;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  typedef struct packed {
    opcode_t     op;
    logic [1:0]  dir;
    logic [7:0]  proto;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] smask;
    logic [31:0] dmask;
    logic [1:0]  pclass;
    logic        act;
  } filter_txn_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [1:0]  in_direction;
  logic [7:0]  in_ip_protocol;
  logic [31:0] in_src_address;
  logic [31:0] in_dst_address;
  logic [15:0] in_src_port_num;
  logic [15:0] in_dst_port_num;
  logic [31:0] in_src_mask;
  logic [31:0] in_dst_mask;
  logic [1:0]  in_rule_proto_class;
  logic        in_rule_verdict;
  logic        out_valid;
  logic        out_verdict;
  logic        out_rule_hit;
  logic [5:0]  out_hit_index;
  logic        out_table_full;

  int unsigned error_count;
  int unsigned pending;
  int unsigned appends_stored;
  int unsigned appends_refused;
  int unsigned packets_seen;
  int unsigned packets_hit;

  // Rules sent so far, used to aim packets at stored entries.
  filter_txn_t rule_seeds[MAX_RULES];
  int unsigned rules_sent = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  first_match_packet_rule_filter #(
    .MAX_RULES(MAX_RULES)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_direction        (in_direction),
    .in_ip_protocol      (in_ip_protocol),
    .in_src_address      (in_src_address),
    .in_dst_address      (in_dst_address),
    .in_src_port_num     (in_src_port_num),
    .in_dst_port_num     (in_dst_port_num),
    .in_src_mask         (in_src_mask),
    .in_dst_mask         (in_dst_mask),
    .in_rule_proto_class (in_rule_proto_class),
    .in_rule_verdict     (in_rule_verdict),
    .out_valid           (out_valid),
    .out_verdict         (out_verdict),
    .out_rule_hit        (out_rule_hit),
    .out_hit_index       (out_hit_index),
    .out_table_full      (out_table_full)
  );

  fmprf_verdict_checker #(
    .MAX_RULES(MAX_RULES)
  ) verdict_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_direction        (in_direction),
    .in_ip_protocol      (in_ip_protocol),
    .in_src_address      (in_src_address),
    .in_dst_address      (in_dst_address),
    .in_src_port_num     (in_src_port_num),
    .in_dst_port_num     (in_dst_port_num),
    .in_src_mask         (in_src_mask),
    .in_dst_mask         (in_dst_mask),
    .in_rule_proto_class (in_rule_proto_class),
    .in_rule_verdict     (in_rule_verdict),
    .out_valid           (out_valid),
    .out_verdict         (out_verdict),
    .out_rule_hit        (out_rule_hit),
    .out_hit_index       (out_hit_index),
    .out_table_full      (out_table_full),
    .error_count         (error_count),
    .pending             (pending),
    .appends_stored      (appends_stored),
    .appends_refused     (appends_refused),
    .packets_seen        (packets_seen),
    .packets_hit         (packets_hit)
  );

  function automatic filter_txn_t random_txn();
    filter_txn_t t;
    t.op     = opcode_t'($urandom_range(0, 1));
    t.dir    = 2'($urandom);
    t.proto  = 8'($urandom);
    t.saddr  = $urandom;
    t.daddr  = $urandom;
    t.sport  = 16'($urandom);
    t.dport  = 16'($urandom);
    t.smask  = $urandom;
    t.dmask  = $urandom;
    t.pclass = 2'($urandom);
    t.act    = 1'($urandom);
    return t;
  endfunction

  function automatic filter_txn_t rule_txn(input logic [1:0] dir, input logic [31:0] saddr,
                                           input logic [31:0] smask, input logic [31:0] daddr,
                                           input logic [31:0] dmask, input logic [15:0] sport,
                                           input logic [15:0] dport, input logic [1:0] pclass,
                                           input logic act);
    filter_txn_t t;
    t        = '0;
    t.op     = OP_APPEND;
    t.dir    = dir;
    t.saddr  = saddr;
    t.smask  = smask;
    t.daddr  = daddr;
    t.dmask  = dmask;
    t.sport  = sport;
    t.dport  = dport;
    t.pclass = pclass;
    t.act    = act;
    return t;
  endfunction

  function automatic filter_txn_t packet_txn(input logic [1:0] dir, input logic [7:0] proto,
                                             input logic [31:0] saddr, input logic [31:0] daddr,
                                             input logic [15:0] sport, input logic [15:0] dport);
    filter_txn_t t;
    t       = '0;
    t.op    = OP_CLASSIFY;
    t.dir   = dir;
    t.proto = proto;
    t.saddr = saddr;
    t.daddr = daddr;
    t.sport = sport;
    t.dport = dport;
    return t;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 2))
      0:       return {8'd10, 14'd0, 10'($urandom_range(0, 1023))};
      1:       return {16'hC0A8, 6'd0, 2'($urandom), 8'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 3))
      0:       return 16'd80;
      1:       return 16'd443;
      2:       return 16'd53;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 3))
      0:       return PROTO_TCP;
      1:       return PROTO_UDP;
      2:       return PROTO_ICMP;
      default: return 8'($urandom);
    endcase
  endfunction

  // A zero-length prefix needs a mask that is nonzero with its top bit clear.
  function automatic logic [31:0] mask_from_prefix(input int unsigned pfx);
    if (pfx == 0) begin
      return {1'b0, 31'($urandom)} | 32'h1;
    end
    return ~32'h0 << (32 - pfx);
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      2:       return mask_from_prefix(0);
      default: return mask_from_prefix($urandom_range(1, 32));
    endcase
  endfunction

  // Flips a random number of low bits, so prefixes are hit and missed.
  function automatic logic [31:0] near_addr(input logic [31:0] addr);
    int unsigned k;
    if (addr == '0) begin
      return pick_addr();
    end
    k = $urandom_range(0, 32);
    if (k == 0) begin
      return addr;
    end
    return addr ^ ($urandom & (~32'h0 >> (32 - k)));
  endfunction

  function automatic filter_txn_t make_rule();
    filter_txn_t t;
    t    = random_txn();
    t.op = OP_APPEND;
    case ($urandom_range(0, 9))
      0:       t.dir = DIR_NONE;
      1:       t.dir = DIR_RSVD;
      default: t.dir = $urandom_range(0, 1) ? DIR_INBOUND : DIR_OUTBOUND;
    endcase
    t.saddr = ($urandom_range(0, 3) == 0) ? '0 : pick_addr();
    t.daddr = ($urandom_range(0, 3) == 0) ? '0 : pick_addr();
    t.smask = pick_mask();
    t.dmask = pick_mask();
    t.sport = ($urandom_range(0, 99) < 35) ? '0 : pick_port();
    t.dport = ($urandom_range(0, 99) < 35) ? '0 : pick_port();
    return t;
  endfunction

  function automatic filter_txn_t make_packet();
    filter_txn_t t;
    filter_txn_t r;
    t    = random_txn();
    t.op = OP_CLASSIFY;
    if (rules_sent > 0 && $urandom_range(0, 99) < DERIVED_PCT) begin
      r     = rule_seeds[$urandom_range(0, rules_sent - 1)];
      t.dir = ($urandom_range(0, 9) == 0) ? 2'($urandom) : r.dir;
      case (r.pclass)
        CLASS_TCP: t.proto = PROTO_TCP;
        CLASS_UDP: t.proto = PROTO_UDP;
        default:   t.proto = pick_proto();
      endcase
      if ($urandom_range(0, 9) == 0) begin
        t.proto = pick_proto();
      end
      t.saddr = near_addr(r.saddr);
      t.daddr = near_addr(r.daddr);
      t.sport = (r.sport != '0 && $urandom_range(0, 99) < 85) ? r.sport : pick_port();
      t.dport = (r.dport != '0 && $urandom_range(0, 99) < 85) ? r.dport : pick_port();
    end else begin
      t.dir   = 2'($urandom);
      t.proto = pick_proto();
      t.saddr = pick_addr();
      t.daddr = pick_addr();
      t.sport = pick_port();
      t.dport = pick_port();
    end
    return t;
  endfunction

  task automatic put_fields(input filter_txn_t t);
    in_opcode           <= t.op;
    in_direction        <= t.dir;
    in_ip_protocol      <= t.proto;
    in_src_address      <= t.saddr;
    in_dst_address      <= t.daddr;
    in_src_port_num     <= t.sport;
    in_dst_port_num     <= t.dport;
    in_src_mask         <= t.smask;
    in_dst_mask         <= t.dmask;
    in_rule_proto_class <= t.pclass;
    in_rule_verdict     <= t.act;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_txn(input filter_txn_t t, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      put_fields(random_txn());
      @(negedge clk);
    end
    start <= 1'b1;
    put_fields(t);
    do @(posedge clk); while (busy !== 1'b0);
    if (t.op == OP_APPEND && rules_sent < MAX_RULES) begin
      rule_seeds[rules_sent] = t;
      rules_sent++;
    end
    @(negedge clk);
  endtask

  task automatic run_directed();
    filter_txn_t t;
    // A lookup on an empty table, then the all-zero and all-one items.
    send_txn(packet_txn(DIR_INBOUND, PROTO_TCP, 32'h0A010203, 32'h0B000001, 16'd1234,
                        16'd80), 0);
    t = '0;
    send_txn(t, 0);
    t = '1;
    send_txn(t, 0);
    t    = '1;
    t.op = OP_APPEND;
    send_txn(t, 0);
    // Rules 2 to 5: prefixes, exact masks, protocol classes and ports.
    send_txn(rule_txn(DIR_INBOUND, 32'h0A000000, 32'hFF000000, '0, '0, '0, '0,
                      CLASS_TCP, VERDICT_DROP), 0);
    send_txn(rule_txn(DIR_OUTBOUND, 32'hFFFFFFFF, '0, 32'hC0A80101, 32'hFFFFFFFF,
                      16'hFFFF, 16'd443, CLASS_UDP, VERDICT_ACCEPT), 0);
    send_txn(rule_txn(DIR_INBOUND, 32'h0A000001, 32'h00FFFFFF, '0, '0, '0, 16'd53,
                      CLASS_RSVD, VERDICT_ACCEPT), 0);
    send_txn(rule_txn(DIR_OUTBOUND, 32'h80000000, 32'hF0F0F0F0, '0, '0, 16'd1, '0,
                      CLASS_ANY, VERDICT_ACCEPT), 0);
    send_txn(packet_txn(DIR_INBOUND, PROTO_TCP, 32'h0A123456, 32'h01020304, 16'd5,
                        16'd6), 0);
    send_txn(packet_txn(DIR_INBOUND, PROTO_UDP, 32'h0A123456, 32'h01020304, 16'd5,
                        16'd53), 0);
    send_txn(packet_txn(DIR_INBOUND, PROTO_ICMP, 32'h0B000000, 32'h01020304, 16'd5,
                        16'd53), 0);
    send_txn(packet_txn(DIR_OUTBOUND, PROTO_UDP, 32'hFFFFFFFF, 32'hC0A80101, 16'hFFFF,
                        16'd443), 0);
    send_txn(packet_txn(DIR_OUTBOUND, PROTO_TCP, 32'hFFFFFFFF, 32'hC0A80101, 16'hFFFF,
                        16'd443), 0);
    send_txn(packet_txn(DIR_OUTBOUND, PROTO_UDP, 32'hFFFFFFFE, 32'hC0A80101, 16'hFFFF,
                        16'd443), 0);
    send_txn(packet_txn(DIR_OUTBOUND, PROTO_TCP, 32'h8FFFFFFF, 32'h0, 16'd1, 16'd0), 0);
    send_txn(packet_txn(DIR_OUTBOUND, PROTO_ICMP, 32'h8FFFFFFF, 32'h0, 16'd1, 16'd0), 0);
    send_txn(packet_txn(DIR_NONE, PROTO_TCP, 32'h0A000005, 32'h0, 16'd0, 16'd0), 0);
    send_txn(packet_txn(DIR_RSVD, PROTO_TCP, 32'h0A000005, 32'h0, 16'd0, 16'd0), 0);
  endtask

  initial begin
    filter_txn_t t;
    int unsigned idle_pct;
    rst_n = 1'b0;
    start = 1'b0;
    t     = '0;
    in_opcode           = t.op;
    in_direction        = '0;
    in_ip_protocol      = '0;
    in_src_address      = '0;
    in_dst_address      = '0;
    in_src_port_num     = '0;
    in_dst_port_num     = '0;
    in_src_mask         = '0;
    in_dst_mask         = '0;
    in_rule_proto_class = '0;
    in_rule_verdict     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int i = 0; i < RANDOM_TXNS; i++) begin
      // The receiver cannot be held off; the third phase runs at full rate.
      case (i * 4 / RANDOM_TXNS)
        1:       idle_pct = 87;
        3:       idle_pct = 17;
        default: idle_pct = 0;
      endcase
      t = ($urandom_range(0, 99) < APPEND_PCT) ? make_rule() : make_packet();
      send_txn(t, idle_pct);
    end
    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Stored %0d rules and refused %0d appends on a full table.",
             appends_stored, appends_refused);
    $display("Classified %0d packets, %0d of them decided by a rule.",
             packets_seen, packets_hit);
    if (error_count == 0) begin
      $display("tb_first_match_packet_rule_filter: done, clean");
    end else begin
      $display("tb_first_match_packet_rule_filter: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding.", pending);
    $display("tb_first_match_packet_rule_filter: done, errors");
    $finish;
  end

endmodule

FILE: first_match_packet_rule_filter.f
design/fmprf_pkg.sv
design/fmprf_cell.sv
design/fmprf_match.sv
design/first_match_packet_rule_filter.sv
verif/fmprf_verdict_checker.sv
verif/tb_first_match_packet_rule_filter.sv
